FILE: hdl/utf8v_pkg.sv
// Package with the item types, automaton codes and constants of the UTF-8 validator.
package utf8v_pkg;

    // Bytes of ASCII text are kept in a segment this many bytes after its last high byte.
    localparam logic [1:0] TRAIL_KEEP = 2'd2;

    // Automaton codes, as they appear on utf8_pending.
    localparam logic [2:0] ST_LEAD     = 3'd0;
    localparam logic [2:0] ST_CONT1    = 3'd1;
    localparam logic [2:0] ST_CONT2    = 3'd2;
    localparam logic [2:0] ST_CONT3    = 3'd3;
    localparam logic [2:0] ST_AFTER_E0 = 3'd4;
    localparam logic [2:0] ST_AFTER_ED = 3'd5;
    localparam logic [2:0] ST_AFTER_F0 = 3'd6;
    localparam logic [2:0] ST_AFTER_F4 = 3'd7;

    // Byte range limits used by the automaton.
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD_E0  = 8'hE0;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD_F0  = 8'hF0;
    localparam logic [7:0] LEAD_F4  = 8'hF4;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;
    localparam logic [7:0] E0_LO    = 8'hA0;
    localparam logic [7:0] ED_HI    = 8'h9F;
    localparam logic [7:0] F0_LO    = 8'h90;
    localparam logic [7:0] F4_HI    = 8'h8F;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       forwarded;
        logic       segment_end;
        logic       utf8_invalid;
        logic [2:0] utf8_pending;
    } result_t;

endpackage

FILE: hdl/utf8_validate_highbyte_filter_unit.sv
// Top level of the strict UTF-8 validator with high-byte segment marker.
// The block takes one text byte per item and returns one result item per byte, at a sustained
// rate of one item per cycle while result_ready does not stall it; each accepted item moves from
// the input register to the output register. An input register feeds a short piece of
// logic (the validity automaton and the segment keep counter), whose result lands in an output
// register, so a new item is accepted while a result waits as long as the input register is free.
// The invalid verdict is sticky until reset, and the keep counter carries over buffer ends.
module utf8_validate_highbyte_filter_unit
    import utf8v_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Pipeline registers.
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    result_valid_reg;
    result_t result_reg;

    // Stream state.
    logic [2:0] dfa_state_reg;
    logic [2:0] dfa_state_next;
    logic       invalid_reg;
    logic       invalid_next;
    logic [1:0] keep_reg;
    logic [1:0] keep_next;
    result_t    result_next;

    logic advance;
    logic reject;
    logic [2:0] dfa_step;
    logic [7:0] b;
    logic in_cont;

    // The staged item moves on when the output register is free or being emptied.
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    // Automaton step for the staged byte.
    assign b       = stage_item_reg.data_byte;
    assign in_cont = (b >= CONT_LO) && (b <= CONT_HI);

    always_comb
    begin
        dfa_step = ST_LEAD;
        reject   = 1'b0;
        unique case (dfa_state_reg)
            ST_LEAD:
            begin
                if (!b[7])
                    dfa_step = ST_LEAD;
                else if ((b >= LEAD2_LO) && (b <= LEAD2_HI))
                    dfa_step = ST_CONT1;
                else if (b == LEAD_E0)
                    dfa_step = ST_AFTER_E0;
                else if (b == LEAD_ED)
                    dfa_step = ST_AFTER_ED;
                else if ((b > LEAD_E0) && (b <= LEAD3_HI))
                    dfa_step = ST_CONT2;
                else if (b == LEAD_F0)
                    dfa_step = ST_AFTER_F0;
                else if ((b > LEAD_F0) && (b < LEAD_F4))
                    dfa_step = ST_CONT3;
                else if (b == LEAD_F4)
                    dfa_step = ST_AFTER_F4;
                else
                    reject = 1'b1;
            end
            ST_CONT1:
            begin
                dfa_step = ST_LEAD;
                reject   = !in_cont;
            end
            ST_CONT2:
            begin
                dfa_step = ST_CONT1;
                reject   = !in_cont;
            end
            ST_CONT3:
            begin
                dfa_step = ST_CONT2;
                reject   = !in_cont;
            end
            ST_AFTER_E0:
            begin
                dfa_step = ST_CONT1;
                reject   = !((b >= E0_LO) && (b <= CONT_HI));
            end
            ST_AFTER_ED:
            begin
                dfa_step = ST_CONT1;
                reject   = !((b >= CONT_LO) && (b <= ED_HI));
            end
            ST_AFTER_F0:
            begin
                dfa_step = ST_CONT2;
                reject   = !((b >= F0_LO) && (b <= CONT_HI));
            end
            default:
            begin
                dfa_step = ST_CONT2;
                reject   = !((b >= CONT_LO) && (b <= F4_HI));
            end
        endcase
    end

    // Sticky verdict: once invalid, the automaton stops and reads as expecting a lead byte.
    always_comb
    begin
        if (invalid_reg)
        begin
            invalid_next   = 1'b1;
            dfa_state_next = dfa_state_reg;
        end
        else if (reject)
        begin
            invalid_next   = 1'b1;
            dfa_state_next = ST_LEAD;
        end
        else
        begin
            invalid_next   = 1'b0;
            dfa_state_next = dfa_step;
        end
    end

    // Segment marker and result assembly.
    always_comb
    begin
        result_next             = '0;
        keep_next               = keep_reg;
        if (b[7])
        begin
            result_next.forwarded = 1'b1;
            keep_next             = TRAIL_KEEP;
        end
        else if (keep_reg != 2'd0)
        begin
            result_next.forwarded   = 1'b1;
            keep_next               = keep_reg - 2'd1;
            result_next.segment_end = (keep_next == 2'd0);
        end
        if (stage_item_reg.buffer_end && (keep_next != 2'd0))
            result_next.segment_end = 1'b1;
        result_next.utf8_invalid = invalid_next;
        result_next.utf8_pending = invalid_next ? ST_LEAD : dfa_state_next;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            dfa_state_reg    <= ST_LEAD;
            invalid_reg      <= 1'b0;
            keep_reg         <= 2'd0;
        end
        else
        begin
            if (item_ready)
                stage_valid_reg <= item_valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                dfa_state_reg    <= dfa_state_next;
                invalid_reg      <= invalid_next;
                keep_reg         <= keep_next;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            stage_item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An invalid verdict never clears before reset.
    assert property (@(posedge clk) disable iff (!rst_n) invalid_reg |=> invalid_reg)
        else $error("invalid flag cleared");

    // An invalid stream reports no pending continuations.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.utf8_invalid) |-> (result.utf8_pending == ST_LEAD))
        else $error("pending state shown on invalid stream");

    // A segment only ends at a forwarded byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.segment_end) |-> result.forwarded)
        else $error("segment end on a byte that was not forwarded");

    // The keep counter never exceeds its reload value.
    assert property (@(posedge clk) disable iff (!rst_n) keep_reg <= TRAIL_KEEP)
        else $error("keep counter out of range");

endmodule
